[hw/rtl/swm_pkg.sv]
// Shared constants for the sliding window maximum block.
// Used by the top level; depends on nothing else.
package swm_pkg;

	// Width of the window size register and its value after reset.
	localparam int unsigned CFG_BITS = 7;
	localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

endpackage

[hw/rtl/swm_cell.sv]
// One cell of the running maximum chain.
// Stand-alone module; instantiated in a row by sliding_window_maximum_core.
module swm_cell #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          shift,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic signed [SAMPLE_BITS-1:0] prev_max,
	input  logic                          tap_sel,
	output logic signed [SAMPLE_BITS-1:0] cur_max,
	output logic        [SAMPLE_BITS-1:0] tap_value
);

	logic signed [SAMPLE_BITS-1:0] max_q;

	// The cell at position k holds the maximum of the k+1 newest words. On a new
	// word it takes the neighbor's maximum over one word fewer and folds in the word.
	always_ff @(posedge clk) begin
		if (shift) begin
			max_q <= (prev_max > sample) ? prev_max : sample;
		end
	end

	assign cur_max   = max_q;
	assign tap_value = tap_sel ? max_q : '0;

endmodule

[hw/rtl/sliding_window_maximum_core.sv]
// Sliding window maximum: the result word is registered and valid in the cycle after its
// input word is accepted. Throughput is one word per cycle unless the master side stalls,
// set by the row of cells that each update their running maximum in a single compare
// per cycle. A word gives a result once window_size words have arrived since reset or
// restart. arst_n clears the fill count, the output valid and sets window_size to 3; cell
// contents are not reset and are never read before enough words have passed through them.
module sliding_window_maximum_core
	import swm_pkg::*;
#(
	parameter int unsigned MAX_WINDOW  = 64,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Window size register.
	input  logic                                   cfg_wen,
	input  logic [CFG_BITS-1:0]                    cfg_wdata,
	// Input stream.
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample
	input  logic [0:0]                             s_axis_tuser,  // restart
	// Result stream.
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata   // window_max
);

	localparam int unsigned TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int unsigned NCELL      = MAX_WINDOW - 1;
	localparam int unsigned CW         = $clog2(MAX_WINDOW + 1);
	localparam int unsigned EW         = (CW > CFG_BITS) ? CW : CFG_BITS;
	localparam logic [EW-1:0] MAX_W    = EW'(MAX_WINDOW);
	localparam logic [EW-1:0] RESET_W  = (EW'(WINDOW_RESET) > MAX_W) ? MAX_W
	                                     : EW'(WINDOW_RESET);

	logic [EW-1:0] win_q;
	logic [EW-1:0] win_nxt;
	logic [EW-1:0] fill_q;
	logic [EW-1:0] fill_base;
	logic [EW:0]   fill_inc;
	logic [EW-1:0] fill_nxt;
	logic          accept;
	logic          produce;

	logic signed [SAMPLE_BITS-1:0] sample;
	logic signed [SAMPLE_BITS-1:0] cell_max [NCELL];
	logic        [SAMPLE_BITS-1:0] cell_tap [NCELL];
	logic        [SAMPLE_BITS-1:0] tap_or;
	logic signed [SAMPLE_BITS-1:0] result;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_valid_q;

	assign sample = s_axis_tdata[SAMPLE_BITS-1:0];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	// A zero window acts as one, and anything past the cell row is clipped to it.
	always_comb begin
		priority if (cfg_wdata == '0) begin
			win_nxt = EW'(1);
		end else if (EW'(cfg_wdata) > MAX_W) begin
			win_nxt = MAX_W;
		end else begin
			win_nxt = EW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= RESET_W;
		end else if (cfg_wen) begin
			win_q <= win_nxt;
		end
	end

	// Fill count saturates at the current window, so a shrink yields a result at once.
	assign fill_base = s_axis_tuser[0] ? '0 : fill_q;
	assign fill_inc  = {1'b0, fill_base} + (EW+1)'(1);
	assign fill_nxt  = (fill_inc < {1'b0, win_q}) ? fill_inc[EW-1:0] : win_q;
	assign produce   = (fill_nxt == win_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_nxt;
		end
	end

	// Cell k keeps the maximum of the k+1 newest words; the cell one short of the
	// window is tapped and merged with the arriving word.
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		swm_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.shift    (accept),
			.sample   (sample),
			.prev_max ((k == 0) ? sample : cell_max[(k == 0) ? 0 : k-1]),
			.tap_sel  (win_q == EW'(k + 2)),
			.cur_max  (cell_max[k]),
			.tap_value(cell_tap[k])
		);
	end

	always_comb begin
		tap_or = '0;
		for (int k = 0; k < NCELL; k++) begin
			tap_or = tap_or | cell_tap[k];
		end
	end

	always_comb begin
		if (win_q == EW'(1)) begin
			result = sample;
		end else begin
			result = ($signed(tap_or) > sample) ? $signed(tap_or) : sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && produce) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && produce) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_BITS'($unsigned(out_data_q));

endmodule

[hw/rtl/swm_checker.sv]
// Port-level checks for sliding_window_maximum_core.
// Bound to the top level by the bind statement at the end of this file.
module swm_checker #(
	parameter int unsigned DATA_BITS = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [DATA_BITS-1:0] m_axis_tdata
);

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// The input side never waits on an empty output register.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output register empty");

	// A new result word appears only after an input word was taken.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) ##1 m_axis_tvalid |-> $past(s_acc))
		else $error("result word without an input word");

	// A delivered word with nothing new coming in leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !s_acc |=> !m_axis_tvalid)
		else $error("result word repeated");

endmodule

bind sliding_window_maximum_core swm_checker #(
	.DATA_BITS(TDATA_BITS)
) u_swm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

[test/sliding_window_maximum_core_tb.sv]
// Testbench for sliding_window_maximum_core: directed and random sample streams with random
// stalls on both sides, checked word by word against a monotonic-queue predictor.
// Depends on swm_pkg and the core RTL; needs no other files.
import swm_pkg::*;

class max_tracker;
	localparam int unsigned SLOTS = 64;
	localparam int unsigned MAX_WIN = 64;
	localparam int unsigned POS_MASK = 127;

	logic signed [15:0]  cand_value [SLOTS];
	logic [6:0]          cand_pos [SLOTS];
	int unsigned         head;
	int unsigned         count;
	int unsigned         fill;
	logic [6:0]          next_pos;
	logic [CFG_BITS-1:0] window_reg;
	logic signed [15:0]  expected_max [$];
	int unsigned         mismatch_count;

	function new();
		head = 0;
		count = 0;
		fill = 0;
		next_pos = '0;
		window_reg = WINDOW_RESET;
		mismatch_count = 0;
	endfunction

	function void set_window(logic [CFG_BITS-1:0] v);
		window_reg = v;
	endfunction

	// Zero acts as a window of one; anything past the ring size saturates.
	function int unsigned span();
		if (window_reg == 0)
			return 1;
		if (window_reg > MAX_WIN)
			return MAX_WIN;
		return 32'(window_reg);
	endfunction

	function void take_sample(logic signed [15:0] v, logic rst);
		int unsigned w;
		w = span();
		if (rst) begin
			count = 0;
			fill = 0;
		end
		// Positions wrap at 128, so the age is the masked difference.
		while (count > 0 && ((next_pos - cand_pos[head]) & POS_MASK) >= w) begin
			head = (head + 1) % SLOTS;
			count--;
		end
		while (count > 0 && cand_value[(head + count - 1) % SLOTS] < v)
			count--;
		if (count < SLOTS) begin
			cand_value[(head + count) % SLOTS] = v;
			cand_pos[(head + count) % SLOTS] = next_pos;
			count++;
		end
		next_pos = next_pos + 7'd1;
		fill = (fill + 1 < w) ? fill + 1 : w;
		if (fill >= w)
			expected_max.insert(expected_max.size(), cand_value[head]);
	endfunction

	function void flag(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("window max mismatch: %s", what);
	endfunction

	function void check_max(logic signed [15:0] got);
		logic signed [15:0] want;
		if (expected_max.size() == 0) begin
			flag($sformatf("unexpected word %0d", got));
			return;
		end
		want = expected_max[0];
		expected_max.delete(0);
		if (got !== want)
			flag($sformatf("expected %0d, got %0d", want, got));
	endfunction
endclass

module sliding_window_maximum_core_tb;
	localparam int unsigned DATA_BITS = 16;
	localparam int unsigned PHASES = 12;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_BITS-1:0]  cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [DATA_BITS-1:0] s_axis_tdata;
	logic [0:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [DATA_BITS-1:0] m_axis_tdata;

	bit                   idle_on;
	int unsigned          out_stall;
	max_tracker           tracker = new();

	logic signed [15:0] opening_words [20] = '{
		16'sh7fff, 16'sh8000, 16'sh8000, -16'sd1, 16'sd0,
		16'sd5, 16'sd5, 16'sd4, 16'sd3, 16'sd2,
		16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd1,
		-16'sd5, -16'sd6, -16'sd7, 16'sd100, 16'sd100
	};
	logic [CFG_BITS-1:0] window_plan [8] = '{
		7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd65, 7'd5, 7'd63
	};

	sliding_window_maximum_core #(
		.MAX_WINDOW(64),
		.SAMPLE_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("sliding_window_maximum_core_tb: done, errors");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Valid stays high across back-to-back words; it only drops for a gap.
	task automatic send_word(input logic signed [15:0] v, input logic rst);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tuser <= rst;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_sample(v, rst);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (tracker.expected_max.size() != 0)
			@(posedge clk);
		// A word that gives no result may still be in flight.
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_BITS-1:0] v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tracker.set_window(v);
	endtask

	initial begin
		m_axis_tready = 1'b0;
		out_stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_max($signed(m_axis_tdata));
			if (out_stall > 0) begin
				out_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				out_stall = pick_gap();
			end
		end
	end

	initial begin
		logic [CFG_BITS-1:0] win;
		logic signed [15:0]  ramp;
		logic signed [15:0]  v;
		int unsigned         items;
		int unsigned         style;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		idle_on = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Runs on the reset window of three: extremes, ties, a falling run and two restarts.
		for (int i = 0; i < 20; i++)
			send_word(opening_words[i], i == 0 || i == 15);
		drain_results();

		// Phases, opened with or without a restart, check that a new window length applies mid-stream.
		for (int p = 0; p < PHASES; p++) begin
			if (p < 8)
				win = window_plan[p];
			else
				win = CFG_BITS'($urandom_range(1, 24));
			write_window(win);
			idle_on = ($urandom_range(0, 3) != 0);
			items = (win >= 60) ? 120 : 60;
			style = $urandom_range(0, 3);
			ramp = $signed(16'($urandom));
			for (int i = 0; i < items; i++) begin
				case (style)
				0: begin
					v = $signed(16'($urandom));
					if ($urandom_range(0, 9) == 0)
						v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				end
				1: begin
					v = $signed(16'($urandom_range(0, 8)));
					v = v - 16'sd4;
				end
				2: begin
					ramp = ramp - $signed(16'($urandom_range(0, 3)));
					v = ($urandom_range(0, 15) == 0) ? $signed(16'($urandom)) : ramp;
				end
				default: begin
					ramp = ramp + $signed(16'($urandom_range(0, 3)));
					v = ($urandom_range(0, 15) == 0) ? $signed(16'($urandom)) : ramp;
				end
				endcase
				send_word(v, (i == 0) ? ($urandom_range(0, 1) == 1)
					: ($urandom_range(0, 49) == 0));
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (tracker.mismatch_count == 0)
			$display("sliding_window_maximum_core_tb: done, clean");
		else
			$display("sliding_window_maximum_core_tb: done, errors");
		$finish;
	end
endmodule

[sliding_window_maximum_core.f]
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/sliding_window_maximum_core.sv
hw/rtl/swm_checker.sv
test/sliding_window_maximum_core_tb.sv
